// ===== rtl/mec_pkg.sv =====
package mec_pkg;

    localparam int FRAC_BITS = 28;
    localparam int COUNT_W   = 12;
    localparam int Z_W       = 33;   // z saturates to +/-8, which is +/-2^31
    localparam int SQ_W      = 35;   // z*z >> FRAC_BITS, never negative
    localparam int P_W       = 36;   // z_re*z_im >> FRAC_BITS, signed
    localparam int SUM_W     = 38;   // update sums before saturation
    localparam int T_W       = 16;
    localparam int U_W       = 17;
    localparam int ACC_W     = 80;
    localparam int CHUNK_W   = 32;

    localparam logic [SQ_W:0]             ESC_FOUR = (SQ_W + 1)'(4) << FRAC_BITS;
    localparam logic signed [SUM_W-1:0]   Z_LIM    = SUM_W'(8) <<< FRAC_BITS;
    localparam logic [U_W-1:0]            U_ONE    = U_W'(1) << T_W;

    localparam logic [U_W-1:0] RED_GAIN   = U_W'(2295);
    localparam logic [U_W-1:0] GREEN_GAIN = U_W'(3825);
    localparam logic [U_W-1:0] BLUE_GAIN  = U_W'(4335);

    localparam logic [1:0] COL_RED   = 2'd0;
    localparam logic [1:0] COL_GREEN = 2'd1;
    localparam logic [1:0] COL_BLUE  = 2'd2;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } colour_t;

    typedef struct packed {
        logic               done;
        logic [COUNT_W-1:0] count;
    } orbit_status_t;

    typedef struct packed {
        logic           done;
        logic [T_W-1:0] t;
    } div_status_t;

    typedef struct packed {
        logic    done;
        colour_t colour;
    } colour_status_t;

    function automatic logic signed [Z_W-1:0] sat_z(input logic signed [SUM_W-1:0] v);
        logic signed [Z_W-1:0] r;
        if (v > Z_LIM) begin
            r = Z_W'(Z_LIM);
        end else if (v < -Z_LIM) begin
            r = Z_W'(-Z_LIM);
        end else begin
            r = Z_W'(v);
        end
        return r;
    endfunction

    // Factors of the gradient polynomials; the accumulator starts at t, so four
    // further factors make t^3*u*2295, t^2*u^2*3825 and t*u^3*4335.
    function automatic logic [U_W-1:0] colour_factor(input logic [1:0] sel,
                                                     input logic [1:0] step,
                                                     input logic [T_W-1:0] t,
                                                     input logic [U_W-1:0] u);
        logic [U_W-1:0] f;
        f = '0;
        unique case (sel)
            COL_RED: begin
                case (step)
                    2'd0, 2'd1: f = U_W'(t);
                    2'd2:       f = u;
                    default:    f = RED_GAIN;
                endcase
            end
            COL_GREEN: begin
                case (step)
                    2'd0:       f = U_W'(t);
                    2'd1, 2'd2: f = u;
                    default:    f = GREEN_GAIN;
                endcase
            end
            COL_BLUE: begin
                case (step)
                    2'd3:    f = BLUE_GAIN;
                    default: f = u;
                endcase
            end
            default: f = '0;
        endcase
        return f;
    endfunction

endpackage

// ===== rtl/mandelbrot_escape_colour_unit.sv =====
// Escape-time evaluator for one point c of the Mandelbrot set, given in signed
// Q4.28 on s_tdata. It iterates z = z*z + c from zero with z saturating at +/-8
// until |z|^2 exceeds 4 or the count reaches max_iterations, then returns the
// count together with an RGB gradient colour (black for points that reach the
// limit). Each iteration needs two passes through the step unit (three products,
// then the escape test and update); the colour needs the bit-serial divider
// for t = n/max, n being the final count, and the chunked 32x17 multiplier
// for the three polynomials. The input is taken again as soon as the previous
// point has left the engine, while its result may still wait in the output
// register.
module mandelbrot_escape_colour_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [11:0] cfg_wdata,      // max_iterations
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,        // c_real [31:0], c_imag [63:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata         // iteration_count, red, green, blue, zero pad
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_ORBIT  = 3'd1;
    localparam logic [2:0] ST_DIV    = 3'd2;
    localparam logic [2:0] ST_COLOUR = 3'd3;
    localparam logic [2:0] ST_OUT    = 3'd4;

    logic [2:0]                         state_reg, state_next;
    logic [mec_pkg::COUNT_W-1:0]        max_iter_reg;
    logic [mec_pkg::COUNT_W-1:0]        count_reg;
    mec_pkg::colour_t                   colour_reg;
    logic                               m_tvalid_reg;
    logic [mec_pkg::COUNT_W-1:0]        m_count_reg;
    mec_pkg::colour_t                   m_colour_reg;

    mec_pkg::orbit_status_t             orbit_st;
    mec_pkg::div_status_t               div_st;
    mec_pkg::colour_status_t            colour_st;

    logic s_accept;
    logic inside_set;
    logic div_start;
    logic load_out;

    assign s_tready   = state_reg == ST_IDLE;
    assign s_accept   = s_tvalid && s_tready;
    assign inside_set = orbit_st.count >= max_iter_reg;
    assign div_start  = (state_reg == ST_ORBIT) && orbit_st.done && !inside_set;
    assign load_out   = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);

    mec_orbit u_orbit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (s_accept),
        .c_real   (s_tdata[31:0]),
        .c_imag   (s_tdata[63:32]),
        .max_iter (max_iter_reg),
        .status   (orbit_st)
    );

    mec_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (orbit_st.count),
        .divisor  (max_iter_reg),
        .status   (div_st)
    );

    mec_colour u_colour (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_st.done),
        .t       (div_st.t),
        .status  (colour_st)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_ORBIT;
                end
            end
            ST_ORBIT: begin
                if (orbit_st.done) begin
                    state_next = inside_set ? ST_OUT : ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_st.done) begin
                    state_next = ST_COLOUR;
                end
            end
            ST_COLOUR: begin
                if (colour_st.done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (load_out) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            max_iter_reg <= mec_pkg::COUNT_W'(100);
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                max_iter_reg <= cfg_wdata;
            end
            if (load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_ORBIT && orbit_st.done) begin
            count_reg  <= orbit_st.count;
            colour_reg <= '0;
        end else if (state_reg == ST_COLOUR && colour_st.done) begin
            colour_reg <= colour_st.colour;
        end
        if (load_out) begin
            m_count_reg  <= count_reg;
            m_colour_reg <= colour_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0000, m_colour_reg.blue, m_colour_reg.green, m_colour_reg.red,
                       m_count_reg};

`ifndef SYNTHESIS
    // A reported count never passes the limit.
    a_count_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_count_reg <= max_iter_reg))
        else $error("iteration count above the limit");
`endif

`ifndef SYNTHESIS
    // Points that reach the limit are black.
    a_inside_black: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_count_reg == max_iter_reg)) |-> (m_colour_reg == '0))
        else $error("point inside the set is not black");
`endif

`ifndef SYNTHESIS
    // Once a word is taken, the input is not ready in the following cycle.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !s_tready)
        else $error("input taken again right after a word");
`endif

`ifndef SYNTHESIS
    // The divider and the colour unit only finish in their own phase.
    a_unit_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (!div_st.done || state_reg == ST_DIV) && (!colour_st.done || state_reg == ST_COLOUR))
        else $error("arithmetic unit finished outside its phase");
`endif

endmodule

// ===== rtl/mec_orbit.sv =====
module mec_orbit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic signed [31:0]            c_real,
    input  logic signed [31:0]            c_imag,
    input  logic [mec_pkg::COUNT_W-1:0]   max_iter,
    output mec_pkg::orbit_status_t        status
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_UPD  = 2'd2;

    logic [1:0] state_reg, state_next;

    logic signed [31:0]                  cr_reg, ci_reg;
    logic signed [mec_pkg::Z_W-1:0]      zr_reg, zr_next, zi_reg, zi_next;
    logic [mec_pkg::COUNT_W-1:0]         count_reg, count_next;
    logic [mec_pkg::SQ_W-1:0]            sr_reg, si_reg;
    logic signed [mec_pkg::P_W-1:0]      p_reg;

    logic signed [2*mec_pkg::Z_W-1:0]    prod_rr, prod_ii, prod_ri;
    logic [mec_pkg::SQ_W:0]              mag_sum;
    logic signed [mec_pkg::SUM_W-1:0]    re_sum, im_sum;
    logic                                stop;

    // The step unit: three products of the current z, registered, then the
    // escape test and the update in the following cycle.
    assign prod_rr = zr_reg * zr_reg;
    assign prod_ii = zi_reg * zi_reg;
    assign prod_ri = zr_reg * zi_reg;

    assign mag_sum = {1'b0, sr_reg} + {1'b0, si_reg};
    assign stop    = (mag_sum > mec_pkg::ESC_FOUR) || (count_reg >= max_iter);
    assign im_sum  = {p_reg[mec_pkg::P_W-1], p_reg, 1'b0} + mec_pkg::SUM_W'(ci_reg);
    assign re_sum  = {3'b000, sr_reg} - {3'b000, si_reg} + mec_pkg::SUM_W'(cr_reg);

    always_comb begin
        state_next = state_reg;
        zr_next    = zr_reg;
        zi_next    = zi_reg;
        count_next = count_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    zr_next    = '0;
                    zi_next    = '0;
                    count_next = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                state_next = ST_UPD;
            end
            ST_UPD: begin
                if (stop) begin
                    state_next = ST_IDLE;
                end else begin
                    zr_next    = mec_pkg::sat_z(re_sum);
                    zi_next    = mec_pkg::sat_z(im_sum);
                    count_next = count_reg + 1'b1;
                    state_next = ST_MUL;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start && state_reg == ST_IDLE) begin
            cr_reg <= c_real;
            ci_reg <= c_imag;
        end
        zr_reg    <= zr_next;
        zi_reg    <= zi_next;
        count_reg <= count_next;
        if (state_reg == ST_MUL) begin
            sr_reg <= prod_rr[mec_pkg::FRAC_BITS+mec_pkg::SQ_W-1:mec_pkg::FRAC_BITS];
            si_reg <= prod_ii[mec_pkg::FRAC_BITS+mec_pkg::SQ_W-1:mec_pkg::FRAC_BITS];
            // An arithmetic shift of the exact product rounds toward minus infinity.
            p_reg  <= prod_ri[mec_pkg::FRAC_BITS+mec_pkg::P_W-1:mec_pkg::FRAC_BITS];
        end
    end

    assign status.done  = (state_reg == ST_UPD) && stop;
    assign status.count = count_reg;

endmodule

// ===== rtl/mec_divider.sv =====
module mec_divider (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [mec_pkg::COUNT_W-1:0]   dividend,
    input  logic [mec_pkg::COUNT_W-1:0]   divisor,
    output mec_pkg::div_status_t          status
);

    logic                              busy_reg;
    logic                              done_reg;
    logic [3:0]                        step_reg;
    logic [mec_pkg::COUNT_W-1:0]       rem_reg;
    logic [mec_pkg::T_W-1:0]           q_reg;
    logic [mec_pkg::COUNT_W:0]         trial;
    logic                              fits;

    // Restoring division, one quotient bit per cycle. The dividend is below
    // the divisor, so the quotient of dividend*2^16 fits in sixteen bits.
    assign trial = {rem_reg, 1'b0};
    assign fits  = trial >= {1'b0, divisor};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start && !busy_reg) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == 4'(mec_pkg::T_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start && !busy_reg) begin
            rem_reg <= dividend;
            q_reg   <= '0;
        end else if (busy_reg) begin
            rem_reg <= fits ? mec_pkg::COUNT_W'(trial - {1'b0, divisor})
                            : mec_pkg::COUNT_W'(trial);
            q_reg   <= {q_reg[mec_pkg::T_W-2:0], fits};
        end
    end

    assign status.done = done_reg;
    assign status.t    = q_reg;

endmodule

// ===== rtl/mec_colour.sv =====
module mec_colour (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [mec_pkg::T_W-1:0]   t,
    output mec_pkg::colour_status_t   status
);

    logic                             busy_reg;
    logic                             done_reg;
    logic [1:0]                       sel_reg;
    logic [1:0]                       step_reg;
    logic [1:0]                       chunk_reg;
    logic [mec_pkg::T_W-1:0]          t_reg;
    logic [mec_pkg::ACC_W-1:0]        acc_reg;
    logic [mec_pkg::ACC_W-1:0]        prod_reg;
    mec_pkg::colour_t                 colour_reg;

    logic [mec_pkg::U_W-1:0]          u;
    logic [mec_pkg::U_W-1:0]          factor;
    logic [mec_pkg::CHUNK_W-1:0]      slice;
    logic [mec_pkg::CHUNK_W+mec_pkg::U_W-1:0] partial;
    logic [mec_pkg::ACC_W-1:0]        shifted;
    logic [mec_pkg::ACC_W-1:0]        sum;
    logic                             last_chunk;
    logic                             last_step;

    assign u      = mec_pkg::U_ONE - mec_pkg::U_W'(t_reg);
    assign factor = mec_pkg::colour_factor(sel_reg, step_reg, t_reg, u);

    // The wide accumulator is multiplied by a narrow factor one 32-bit chunk
    // per cycle; the partial products are added into the new product.
    always_comb begin
        case (chunk_reg)
            2'd0:    slice = acc_reg[31:0];
            2'd1:    slice = acc_reg[63:32];
            default: slice = {16'b0, acc_reg[79:64]};
        endcase
        partial = (mec_pkg::CHUNK_W + mec_pkg::U_W)'(slice)
                * (mec_pkg::CHUNK_W + mec_pkg::U_W)'(factor);
        case (chunk_reg)
            2'd0:    shifted = mec_pkg::ACC_W'(partial);
            2'd1:    shifted = {partial[47:0], 32'b0};
            default: shifted = {partial[15:0], 64'b0};
        endcase
        sum = prod_reg + shifted;
    end

    assign last_chunk = chunk_reg == 2'd2;
    assign last_step  = step_reg == 2'd3;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            sel_reg   <= mec_pkg::COL_RED;
            step_reg  <= '0;
            chunk_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start && !busy_reg) begin
                busy_reg  <= 1'b1;
                sel_reg   <= mec_pkg::COL_RED;
                step_reg  <= '0;
                chunk_reg <= '0;
            end else if (busy_reg) begin
                if (!last_chunk) begin
                    chunk_reg <= chunk_reg + 1'b1;
                end else begin
                    chunk_reg <= '0;
                    step_reg  <= step_reg + 1'b1;
                    if (last_step) begin
                        if (sel_reg == mec_pkg::COL_BLUE) begin
                            busy_reg <= 1'b0;
                            done_reg <= 1'b1;
                        end else begin
                            sel_reg <= sel_reg + 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start && !busy_reg) begin
            t_reg    <= t;
            acc_reg  <= mec_pkg::ACC_W'(t);
            prod_reg <= '0;
        end else if (busy_reg) begin
            if (!last_chunk) begin
                prod_reg <= sum;
            end else begin
                prod_reg <= '0;
                if (last_step) begin
                    acc_reg <= mec_pkg::ACC_W'(t_reg);
                    unique case (sel_reg)
                        mec_pkg::COL_RED:   colour_reg.red   <= sum[71:64];
                        mec_pkg::COL_GREEN: colour_reg.green <= sum[71:64];
                        mec_pkg::COL_BLUE:  colour_reg.blue  <= sum[72:65];
                        default:            colour_reg.blue  <= sum[72:65];
                    endcase
                end else begin
                    acc_reg <= sum;
                end
            end
        end
    end

    assign status.done   = done_reg;
    assign status.colour = colour_reg;

endmodule
